/* rtl/htu_pkg.sv */
// Package: widths, opcodes, status codes, beat types and fixed-point constants of the transform unit.
`default_nettype none
package htu_pkg;
  localparam int WORD_WIDTH    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int MAT_DEPTH     = 16;
  localparam int MAT_AW        = $clog2(MAT_DEPTH);
  localparam int PROD_WIDTH    = 2 * WORD_WIDTH;
  localparam int ACC_WIDTH     = PROD_WIDTH + 2;
  localparam int SH_WIDTH      = ACC_WIDTH - FRACTION_BITS;
  localparam int NUM_WIDTH     = WORD_WIDTH + FRACTION_BITS;

  localparam logic [2:0] OP_WR_CUR  = 3'd0;
  localparam logic [2:0] OP_WR_OPR  = 3'd1;
  localparam logic [2:0] OP_POST    = 3'd2;
  localparam logic [2:0] OP_PRE     = 3'd3;
  localparam logic [2:0] OP_COL_PT  = 3'd4;
  localparam logic [2:0] OP_ROW_PT  = 3'd5;
  localparam logic [2:0] OP_COL_DIR = 3'd6;
  localparam logic [2:0] OP_ROW_DIR = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WZERO = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic signed [WORD_WIDTH-1:0] ONE_FX =
    WORD_WIDTH'(64'sd1 <<< FRACTION_BITS);
  localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [2:0]                   opcode;
    logic [1:0]                   row_index;
    logic [1:0]                   col_index;
    logic signed [WORD_WIDTH-1:0] element_value;
    logic signed [WORD_WIDTH-1:0] x_coord;
    logic signed [WORD_WIDTH-1:0] y_coord;
    logic signed [WORD_WIDTH-1:0] z_coord;
  } htu_in_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] x_result;
    logic signed [WORD_WIDTH-1:0] y_result;
    logic signed [WORD_WIDTH-1:0] z_result;
    logic [1:0]                   status;
  } htu_out_t;
endpackage
`default_nettype wire

/* rtl/htu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module htu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/homogeneous_transform_unit.sv */
// Top level: 4x4 homogeneous matrix unit with RAM-held matrices and one shared MAC.
//
// Input beats (in_valid/in_ready, htu_in_t) carry an opcode. Element writes are
// taken in the idle state and leave the unit there. A matrix product runs four
// groups, each of sixteen products through the single multiplier read from the
// two matrix RAMs, a pipeline drain, then write-back of the four-entry row or
// column buffer. A direction transform runs sixteen products plus drain; a
// point transform adds a restoring divider that produces one quotient bit per
// cycle for each of the three components. One item is in work at a time.
// Transforms return one beat on out_valid/out_ready (htu_out_t); the result is
// held in an output register, so a new input beat is taken while it waits. If
// the receiver stalls and a second result is ready, the unit waits in its final
// state until the register frees.
// Reset (rst, synchronous) makes the current matrix identity and the operand
// matrix zero through per-entry valid bits; no clearing pass is needed.
`default_nettype none
module homogeneous_transform_unit
  import htu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire htu_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output htu_out_t      out_data
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WBACK = 3'd3;
  localparam logic [2:0] S_DSET  = 3'd4;
  localparam logic [2:0] S_DRUN  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] op;
  logic [3:0] cnt;
  logic [1:0] grp;
  logic [1:0] wcnt;
  logic [1:0] de;
  logic [5:0] dcnt;
  logic signed [WORD_WIDTH-1:0] vec [3];

  logic [MAT_DEPTH-1:0] cur_vld, opr_vld;
  logic                 cur_we;
  logic [MAT_AW-1:0]    cur_waddr, cur_raddr, opr_raddr, cur_ra_q;
  logic [WORD_WIDTH-1:0] cur_wdata, cur_rdata, opr_rdata;
  logic                 cur_rv, opr_rv;
  logic                 opr_we;

  logic       s1_v, s2_v, fin_v;
  logic [1:0] s1_k, s1_a, s2_k, s2_a, fin_a;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [WORD_WIDTH-1:0] res [4];
  logic [3:0] satf;

  logic [NUM_WIDTH-1:0]  dq;
  logic [WORD_WIDTH-1:0] drem, dd;
  logic                  dneg, dsat;
  logic signed [WORD_WIDTH-1:0] qres [3];

  logic is_mat, is_point;
  assign is_mat   = (op == OP_POST) || (op == OP_PRE);
  assign is_point = (op == OP_COL_PT) || (op == OP_ROW_PT);

  assign in_ready = (state == S_IDLE);

  htu_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MAT_DEPTH)) u_cur (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rdata));

  htu_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MAT_DEPTH)) u_opr (
    .clk(clk), .we(opr_we), .waddr({in_data.row_index, in_data.col_index}),
    .wdata(in_data.element_value), .raddr(opr_raddr), .rdata(opr_rdata));

  logic accept;
  assign accept = in_valid && in_ready;
  assign opr_we = accept && (in_data.opcode == OP_WR_OPR);

  always_comb begin
    if (state == S_WBACK) begin
      cur_we    = 1'b1;
      cur_waddr = (op == OP_POST) ? {grp, wcnt} : {wcnt, grp};
      cur_wdata = res[wcnt];
    end else begin
      cur_we    = accept && (in_data.opcode == OP_WR_CUR);
      cur_waddr = {in_data.row_index, in_data.col_index};
      cur_wdata = in_data.element_value;
    end
  end

  // read addresses for term k of element a in group grp
  always_comb begin
    unique case (op) inside
      OP_POST: begin
        cur_raddr = {grp, cnt[1:0]};
        opr_raddr = {cnt[1:0], cnt[3:2]};
      end
      OP_PRE: begin
        cur_raddr = {cnt[1:0], grp};
        opr_raddr = {cnt[3:2], cnt[1:0]};
      end
      OP_COL_PT, OP_COL_DIR: begin
        cur_raddr = {cnt[3:2], cnt[1:0]};
        opr_raddr = '0;
      end
      default: begin
        cur_raddr = {cnt[1:0], cnt[3:2]};
        opr_raddr = '0;
      end
    endcase
  end

  logic signed [WORD_WIDTH-1:0] op_a, op_b;
  always_comb begin
    if (cur_rv) op_a = cur_rdata;
    else if (cur_ra_q[3:2] == cur_ra_q[1:0]) op_a = ONE_FX;
    else op_a = '0;
    if (is_mat) op_b = opr_rv ? opr_rdata : '0;
    else if (s1_k == 2'd3) op_b = is_point ? ONE_FX : '0;
    else op_b = vec[s1_k];
  end

  logic signed [SH_WIDTH-1:0] acc_sh;
  logic                       acc_ovf;
  logic signed [WORD_WIDTH-1:0] acc_val;
  assign acc_sh  = acc[ACC_WIDTH-1:FRACTION_BITS];
  assign acc_ovf = !((&acc_sh[SH_WIDTH-1:WORD_WIDTH-1]) || !(|acc_sh[SH_WIDTH-1:WORD_WIDTH-1]));
  assign acc_val = acc_ovf ? (acc_sh[SH_WIDTH-1] ? WMIN : WMAX) : acc_sh[WORD_WIDTH-1:0];

  logic [WORD_WIDTH:0]   rem_sh;
  logic                  qbit;
  logic [NUM_WIDTH-1:0]  dq_next;
  logic signed [WORD_WIDTH-1:0] res_e, q_sat;
  logic                  q_ovf;
  assign rem_sh  = {drem, dq[NUM_WIDTH-1]};
  assign qbit    = (rem_sh >= {1'b0, dd});
  assign dq_next = {dq[NUM_WIDTH-2:0], qbit};
  assign res_e   = res[de];
  always_comb begin
    if (dneg) begin
      q_ovf = (dq_next > NUM_WIDTH'({1'b1, {(WORD_WIDTH-1){1'b0}}}));
      q_sat = q_ovf ? WMIN : -$signed(dq_next[WORD_WIDTH-1:0]);
    end else begin
      q_ovf = (dq_next > NUM_WIDTH'(WMAX));
      q_sat = q_ovf ? WMAX : $signed(dq_next[WORD_WIDTH-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    cur_rv   <= cur_vld[cur_raddr];
    opr_rv   <= opr_vld[opr_raddr];
    cur_ra_q <= cur_raddr;
    prod     <= PROD_WIDTH'(op_a * op_b);
    s1_k     <= cnt[1:0];
    s1_a     <= cnt[3:2];
    s2_k     <= s1_k;
    s2_a     <= s1_a;
    fin_a    <= s2_a;
    if (s2_v) begin
      acc <= (s2_k == 2'd0) ? ACC_WIDTH'(prod) : acc + ACC_WIDTH'(prod);
    end
    if (fin_v) begin
      res[fin_a]  <= acc_val;
      satf[fin_a] <= acc_ovf;
    end
    if (accept) begin
      vec[0] <= in_data.x_coord;
      vec[1] <= in_data.y_coord;
      vec[2] <= in_data.z_coord;
    end
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_WR_CUR;
      cnt       <= '0;
      grp       <= '0;
      wcnt      <= '0;
      de        <= '0;
      dcnt      <= '0;
      dsat      <= 1'b0;
      cur_vld   <= '0;
      opr_vld   <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      fin_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v  <= (state == S_ISSUE);
      s2_v  <= s1_v;
      fin_v <= s2_v && (s2_k == 2'd3);
      if (cur_we) cur_vld[cur_waddr] <= 1'b1;
      if (opr_we) opr_vld[{in_data.row_index, in_data.col_index}] <= 1'b1;
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= in_data.opcode;
            cnt <= '0;
            grp <= '0;
            if (in_data.opcode != OP_WR_CUR && in_data.opcode != OP_WR_OPR) begin
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (fin_v && fin_a == 2'd3) begin
            wcnt <= '0;
            de   <= '0;
            dsat <= 1'b0;
            if (is_mat) state <= S_WBACK;
            else if (is_point && acc_val != '0) state <= S_DSET;
            else state <= S_FIN;
          end
        end
        S_WBACK: begin
          wcnt <= wcnt + 2'd1;
          if (wcnt == 2'd3) begin
            grp <= grp + 2'd1;
            cnt <= '0;
            state <= (grp == 2'd3) ? S_IDLE : S_ISSUE;
          end
        end
        S_DSET: begin
          dq    <= {(res_e[WORD_WIDTH-1] ? WORD_WIDTH'(-res_e) : WORD_WIDTH'(res_e)),
                    {FRACTION_BITS{1'b0}}};
          dd    <= res[3][WORD_WIDTH-1] ? WORD_WIDTH'(-res[3]) : WORD_WIDTH'(res[3]);
          dneg  <= res_e[WORD_WIDTH-1] ^ res[3][WORD_WIDTH-1];
          drem  <= '0;
          dcnt  <= 6'(NUM_WIDTH - 1);
          state <= S_DRUN;
        end
        S_DRUN: begin
          drem <= qbit ? WORD_WIDTH'(rem_sh - {1'b0, dd}) : rem_sh[WORD_WIDTH-1:0];
          dq   <= dq_next;
          dcnt <= dcnt - 6'd1;
          if (dcnt == '0) begin
            qres[de] <= q_sat;
            dsat     <= dsat | q_ovf;
            de       <= de + 2'd1;
            state    <= (de == 2'd2) ? S_FIN : S_DSET;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (is_point && res[3] == '0) begin
              out_data.x_result <= '0;
              out_data.y_result <= '0;
              out_data.z_result <= '0;
              out_data.status   <= ST_WZERO;
            end else if (is_point) begin
              out_data.x_result <= qres[0];
              out_data.y_result <= qres[1];
              out_data.z_result <= qres[2];
              out_data.status   <= (dsat || (|satf)) ? ST_SAT : ST_OK;
            end else begin
              out_data.x_result <= res[0];
              out_data.y_result <= res[1];
              out_data.z_result <= res[2];
              out_data.status   <= (|satf[2:0]) ? ST_SAT : ST_OK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRUN) |-> (dd != '0))
    else $error("divide by zero w");
  a_fin_in_run: assert property (@(posedge clk) disable iff (rst)
    fin_v |-> (state == S_ISSUE || state == S_DRAIN))
    else $error("accumulator result outside product phase");
  a_no_write_in_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE || state == S_DRAIN) |-> !cur_we)
    else $error("matrix write during product reads");
  a_s1_follows_issue: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> $past(state) == S_ISSUE)
    else $error("read beat without issue");
`endif
endmodule
`default_nettype wire

/* dv/homogeneous_transform_unit_tb.sv */
// Self-checking testbench for the homogeneous transform unit: in-bench model, directed cases and random traffic.
module homogeneous_transform_unit_tb
  import htu_pkg::*;
();

  typedef struct {
    htu_in_t beat;
    bit      hold;
    int      idle_pct;
    int      stall_pct;
  } pending_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  htu_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  htu_out_t out_data;

  pending_t pending_q[$];
  htu_out_t expected_q[$];
  logic signed [WORD_WIDTH-1:0] cur_mat[16];
  logic signed [WORD_WIDTH-1:0] opr_mat[16];
  int idle_pct;
  int stall_pct;
  int errors;
  int n_beats;
  int n_results;
  int n_wzero;
  int n_sat;
  int quiet_cycles;
  int phase_idle;
  int phase_stall;

  homogeneous_transform_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [WORD_WIDTH-1:0] clamp_word(
      input logic signed [127:0] a, inout bit ovf);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = WMAX;
    lo = WMIN;
    if (a > hi) begin
      ovf = 1'b1;
      return WMAX;
    end
    if (a < lo) begin
      ovf = 1'b1;
      return WMIN;
    end
    return a[WORD_WIDTH-1:0];
  endfunction

  task automatic mat_product(input logic signed [WORD_WIDTH-1:0] a[16],
                             input logic signed [WORD_WIDTH-1:0] b[16]);
    logic signed [WORD_WIDTH-1:0] tmp[16];
    logic signed [127:0] acc;
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    bit ovf;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          wa = a[i*4+k];
          wb = b[k*4+j];
          acc = acc + wa * wb;
        end
        tmp[i*4+j] = clamp_word(acc >>> FRACTION_BITS, ovf);
      end
    end
    cur_mat = tmp;
  endtask

  task automatic apply_beat(input htu_in_t b);
    logic signed [WORD_WIDTH-1:0] v[3];
    logic signed [WORD_WIDTH-1:0] val[4];
    logic signed [127:0] acc;
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] num;
    logic signed [127:0] den;
    htu_out_t r;
    bit ovf;
    bit col;
    bit point;
    int n;
    n_beats++;
    case (b.opcode)
      OP_WR_CUR: begin
        cur_mat[b.row_index*4+b.col_index] = b.element_value;
      end
      OP_WR_OPR: begin
        opr_mat[b.row_index*4+b.col_index] = b.element_value;
      end
      OP_POST: mat_product(cur_mat, opr_mat);
      OP_PRE:  mat_product(opr_mat, cur_mat);
      default: begin
        ovf = 1'b0;
        col = (b.opcode == OP_COL_PT) || (b.opcode == OP_COL_DIR);
        point = (b.opcode == OP_COL_PT) || (b.opcode == OP_ROW_PT);
        v[0] = b.x_coord;
        v[1] = b.y_coord;
        v[2] = b.z_coord;
        n = point ? 4 : 3;
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) begin
            wa = col ? cur_mat[i*4+k] : cur_mat[k*4+i];
            wb = v[k];
            acc = acc + wa * wb;
          end
          if (point) begin
            wa = col ? cur_mat[i*4+3] : cur_mat[12+i];
            acc = acc + (wa <<< FRACTION_BITS);
          end
          val[i] = clamp_word(acc >>> FRACTION_BITS, ovf);
        end
        if (point && val[3] == 0) begin
          r.x_result = '0;
          r.y_result = '0;
          r.z_result = '0;
          r.status = ST_WZERO;
        end else begin
          for (int i = 0; i < 3; i++) begin
            num = val[i];
            if (point) begin
              den = val[3];
              num = (num <<< FRACTION_BITS) / den;
            end
            val[i] = clamp_word(num, ovf);
          end
          r.x_result = val[0];
          r.y_result = val[1];
          r.z_result = val[2];
          r.status = ovf ? ST_SAT : ST_OK;
        end
        expected_q.push_back(r);
      end
    endcase
  endtask

  task automatic report(input string what, input logic [WORD_WIDTH-1:0] got,
                        input logic [WORD_WIDTH-1:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  task automatic add(input htu_in_t b, input int ip, input int sp);
    pending_t p;
    p.beat = b;
    p.hold = 1'b0;
    p.idle_pct = ip;
    p.stall_pct = sp;
    pending_q.push_back(p);
  endtask

  task automatic add_hold();
    pending_t p;
    p.beat = '0;
    p.hold = 1'b1;
    p.idle_pct = 0;
    p.stall_pct = 0;
    pending_q.push_back(p);
  endtask

  function automatic htu_in_t mk(input logic [2:0] op, input int r, input int c,
                                 input logic [31:0] e, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] z);
    htu_in_t b;
    b.opcode = op;
    b.row_index = r[1:0];
    b.col_index = c[1:0];
    b.element_value = e;
    b.x_coord = x;
    b.y_coord = y;
    b.z_coord = z;
    return b;
  endfunction

  function automatic logic [31:0] rand_fx();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    if (pick < 85) return $urandom;
    case ($urandom_range(3))
      0: return 32'd0;
      1: return ONE_FX;
      2: return WMAX;
      default: return WMIN;
    endcase
  endfunction

  function automatic htu_in_t rand_beat();
    int pick;
    htu_in_t b;
    b = mk(OP_WR_CUR, $urandom_range(3), $urandom_range(3), rand_fx(),
           rand_fx(), rand_fx(), rand_fx());
    pick = $urandom_range(99);
    if (pick < 28) begin
      b.opcode = OP_WR_CUR;
      if ($urandom_range(3) == 0) begin
        b.row_index = 2'd3;
        b.col_index = 2'd3;
        b.element_value = ONE_FX;
      end
    end else if (pick < 40) b.opcode = OP_WR_OPR;
    else if (pick < 45) b.opcode = OP_POST;
    else if (pick < 50) b.opcode = OP_PRE;
    else b.opcode = 3'($urandom_range(OP_COL_PT, OP_ROW_DIR));
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      out_ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) apply_beat(in_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (pending_q.size() != 0 && pending_q[0].hold && expected_q.size() == 0
          && !out_valid && !(in_valid && !in_ready))
        void'(pending_q.pop_front());
      if (!in_valid || in_ready) begin
        if (pending_q.size() == 0 || pending_q[0].hold
            || $urandom_range(99) < idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          idle_pct = pending_q[0].idle_pct;
          stall_pct = pending_q[0].stall_pct;
          in_data <= pending_q[0].beat;
          in_valid <= 1'b1;
          void'(pending_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected beat", out_data.x_result, '0);
      end else begin
        if (out_data.x_result !== expected_q[0].x_result)
          report("x_result", out_data.x_result, expected_q[0].x_result);
        if (out_data.y_result !== expected_q[0].y_result)
          report("y_result", out_data.y_result, expected_q[0].y_result);
        if (out_data.z_result !== expected_q[0].z_result)
          report("z_result", out_data.z_result, expected_q[0].z_result);
        if (out_data.status !== expected_q[0].status)
          report("status", 32'(out_data.status), 32'(expected_q[0].status));
        if (expected_q[0].status == ST_WZERO) n_wzero++;
        if (expected_q[0].status == ST_SAT) n_sat++;
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && quiet_cycles > 20000) begin
      $display("timeout: no beat accepted for %0d cycles", quiet_cycles);
      $display("homogeneous_transform_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) begin
      cur_mat[i] = (i % 5 == 0) ? ONE_FX : '0;
      opr_mat[i] = '0;
    end
    errors = 0;
    n_beats = 0;
    n_results = 0;
    n_wzero = 0;
    n_sat = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;

    add(mk(OP_COL_PT, 0, 0, 0, WMAX, WMIN, ONE_FX), 0, 0);
    add(mk(OP_ROW_PT, 0, 0, 0, WMIN, WMAX, 32'hFFFFFFFF), 0, 0);
    add(mk(OP_COL_DIR, 0, 0, 0, WMAX, 32'd0, WMIN), 0, 0);
    add(mk(OP_ROW_DIR, 0, 0, 0, 32'd1, 32'hFFFFFFFF, WMAX), 0, 0);
    add(mk(OP_WR_CUR, 3, 3, 32'd0, 0, 0, 0), 0, 0);
    add(mk(OP_COL_PT, 0, 0, 0, ONE_FX, ONE_FX, ONE_FX), 0, 0);
    add(mk(OP_ROW_PT, 0, 0, 0, WMAX, WMAX, WMAX), 0, 0);
    add(mk(OP_WR_CUR, 3, 3, 32'h00008000, 0, 0, 0), 0, 0);
    add(mk(OP_COL_PT, 0, 0, 0, WMAX, WMIN, 32'h00030000), 0, 0);
    add(mk(OP_WR_CUR, 3, 3, ONE_FX, 0, 0, 0), 0, 0);
    add(mk(OP_WR_CUR, 0, 0, WMAX, 0, 0, 0), 0, 0);
    add(mk(OP_COL_DIR, 0, 0, 0, WMAX, WMAX, WMAX), 0, 0);
    add(mk(OP_WR_CUR, 0, 3, WMIN, 0, 0, 0), 0, 0);
    add(mk(OP_ROW_PT, 0, 0, 0, WMIN, 32'h00010000, 32'd5), 0, 0);
    add(mk(OP_WR_OPR, 0, 0, 32'h00020000, 0, 0, 0), 0, 0);
    add(mk(OP_WR_OPR, 3, 3, ONE_FX, 0, 0, 0), 0, 0);
    add(mk(OP_WR_OPR, 1, 2, 32'hFFFF8000, 0, 0, 0), 0, 0);
    add(mk(OP_POST, 0, 0, 0, 0, 0, 0), 0, 0);
    add(mk(OP_COL_PT, 0, 0, 0, 32'h00010000, 32'h00020000, 32'hFFFD0000), 0, 0);
    add(mk(OP_PRE, 0, 0, 0, 0, 0, 0), 0, 0);
    add(mk(OP_ROW_DIR, 0, 0, 0, 32'h12345678, 32'h87654321, 32'h7F00FF00), 0, 0);
    add(mk(OP_WR_OPR, 2, 1, WMIN, 0, 0, 0), 0, 0);
    add(mk(OP_PRE, 0, 0, 0, 0, 0, 0), 0, 0);
    add(mk(OP_ROW_PT, 0, 0, 0, 32'h00011111, 32'hFFFE0000, 32'h00000001), 0, 0);
    add_hold();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin phase_idle = 0;  phase_stall = 0;  end
        1: begin phase_idle = 60; phase_stall = 0;  end
        2: begin phase_idle = 0;  phase_stall = 60; end
        default: begin phase_idle = 26; phase_stall = 26; end
      endcase
      for (int i = 0; i < 113; i++) begin
        add(rand_beat(), phase_idle, phase_stall);
        if (i == 56) add_hold();
      end
      add_hold();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d input beats, %0d results (%0d zero-w, %0d saturated)",
             n_beats, n_results, n_wzero, n_sat);
    $display("idle phases: none, sender 60%%, receiver 60%%, both 26%%; %0d left over",
             expected_q.size());
    if (errors == 0 && expected_q.size() == 0) begin
      $display("homogeneous_transform_unit_tb OK");
    end else begin
      $display("homogeneous_transform_unit_tb NOT OK");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/htu_pkg.sv
rtl/htu_ram.sv
rtl/homogeneous_transform_unit.sv
dv/homogeneous_transform_unit_tb.sv
